FILE: src/tmv_pkg.sv
// tmv_pkg: shared widths, register codes, reset values and types for trial_mean_variance.
// No dependencies; imported by every module of the block.
package tmv_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int LEN_W     = 21;
    localparam int CNT_W     = 16;
    localparam int SUM_W     = 28;
    localparam int SUMSQ_W   = 36;
    localparam int MEAN_W    = 28;
    localparam int VAR_W     = 54;
    localparam int K_W       = 5;
    localparam int SH_W      = 6;
    localparam int MEAN_FRAC = 20;
    localparam int VAR_FRAC  = 40;
    localparam int PROD_W    = 2 * SUM_W;

    localparam int DEF_MAX_LOG2_LENGTH = 20;
    localparam int DEF_SAMPLE_BITS     = 8;

    localparam logic [LEN_W-1:0] SAMPLES_PER_TRIAL_RESET = LEN_W'(1024);
    localparam logic [CNT_W-1:0] TRIAL_COUNT_RESET       = CNT_W'(1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_TRIAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIAL_COUNT       = 1'b1;

    // Totals of one finished trial, handed to the statistics stages.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [SUMSQ_W-1:0] sumsq;
        logic [K_W-1:0]     k;
        logic [CNT_W-1:0]   index;
        logic               last;
    } trial_sums_t;

    // floor(log2(len)), len = 0 treated as 1
    function automatic logic [K_W-1:0] log2_floor(input logic [LEN_W-1:0] len);
        logic [K_W-1:0] k;
        k = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (len[i])
            begin
                k = K_W'(i);
            end
        end
        return k;
    endfunction

endpackage

FILE: src/tmv_accum.sv
// tmv_accum: trial position tracking, sum / sum-of-squares accumulation and trial close.
// Depends on tmv_pkg; feeds tmv_stats with one trial_sums_t per finished trial.
module tmv_accum #(
    parameter int MAX_LOG2_LENGTH = tmv_pkg::DEF_MAX_LOG2_LENGTH,
    parameter int SAMPLE_BITS     = tmv_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tmv_pkg::SAMPLE_W-1:0]  sample,
    input  logic [tmv_pkg::LEN_W-1:0]     samples_per_trial,
    input  logic [tmv_pkg::CNT_W-1:0]     trial_count,
    output logic                          sums_valid,
    input  logic                          sums_stall,
    output tmv_pkg::trial_sums_t          sums
);
    import tmv_pkg::*;

    localparam int USED_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << USED_BITS) - 1);
    localparam int K_CAP = (MAX_LOG2_LENGTH < MEAN_FRAC) ? MAX_LOG2_LENGTH : MEAN_FRAC;
    localparam logic [K_W-1:0] K_MAX = K_W'(K_CAP);

    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUMSQ_W-1:0] sumsq_reg, sumsq_next;
    logic [CNT_W-1:0]   trial_reg, trial_next;
    logic               valid_reg, valid_next;
    trial_sums_t        sums_reg, sums_next;

    logic [SAMPLE_W-1:0]   s;
    logic [2*SAMPLE_W-1:0] sq;
    logic [LEN_W-1:0]      len;
    logic [CNT_W-1:0]      cnt;
    logic [K_W-1:0]        k_raw, k;
    logic [LEN_W-1:0]      n;
    logic                  counted, trial_end, last;
    logic [SUM_W-1:0]      sum_upd;
    logic [SUMSQ_W-1:0]    sumsq_upd;
    logic                  accept;

    assign in_stall = valid_reg && sums_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s         = sample & SAMPLE_MASK;
        sq        = {{SAMPLE_W{1'b0}}, s} * {{SAMPLE_W{1'b0}}, s};
        len       = (samples_per_trial == '0) ? LEN_W'(1) : samples_per_trial;
        cnt       = (trial_count == '0) ? CNT_W'(1) : trial_count;
        k_raw     = log2_floor(len);
        k         = (k_raw > K_MAX) ? K_MAX : k_raw;
        n         = LEN_W'(1) << k;
        counted   = pos_reg < n;
        sum_upd   = counted ? sum_reg + SUM_W'(s) : sum_reg;
        sumsq_upd = counted ? sumsq_reg + SUMSQ_W'(sq) : sumsq_reg;
        trial_end = ({1'b0, pos_reg} + (LEN_W+1)'(1)) >= {1'b0, len};
        last      = ({1'b0, trial_reg} + (CNT_W+1)'(1)) >= {1'b0, cnt};

        pos_next   = pos_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        trial_next = trial_reg;
        valid_next = valid_reg && sums_stall;
        sums_next  = sums_reg;

        if (accept)
        begin
            if (trial_end)
            begin
                pos_next        = '0;
                sum_next        = '0;
                sumsq_next      = '0;
                trial_next      = last ? '0 : trial_reg + CNT_W'(1);
                valid_next      = 1'b1;
                sums_next.sum   = sum_upd;
                sums_next.sumsq = sumsq_upd;
                sums_next.k     = k;
                sums_next.index = trial_reg;
                sums_next.last  = last;
            end
            else
            begin
                pos_next   = pos_reg + LEN_W'(1);
                sum_next   = sum_upd;
                sumsq_next = sumsq_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            trial_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            trial_reg <= trial_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sums_reg <= sums_next;
    end

    assign sums_valid = valid_reg;
    assign sums       = sums_reg;

endmodule

FILE: src/tmv_stats.sv
// tmv_stats: turns trial totals into fixed-point mean and variance over two register stages.
// Depends on tmv_pkg; stage 1 squares the sum, stage 2 subtracts, scales and saturates.
module tmv_stats (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sums_valid,
    output logic                          sums_stall,
    input  tmv_pkg::trial_sums_t          sums,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tmv_pkg::CNT_W-1:0]     trial_index,
    output logic [tmv_pkg::MEAN_W-1:0]    mean_fixed,
    output logic [tmv_pkg::VAR_W-1:0]     variance_fixed,
    output logic                          final_trial
);
    import tmv_pkg::*;

    localparam int MEAN_WIDE_W = SUM_W + MEAN_FRAC;
    localparam int VAR_WIDE_W  = PROD_W + VAR_FRAC;
    localparam logic [VAR_W-1:0] VAR_ALL_ONES = '1;

    // product stage
    logic               p_valid_reg, p_valid_next;
    logic [PROD_W-1:0]  p_a_reg, p_a_next;
    logic [PROD_W-1:0]  p_b_reg, p_b_next;
    logic [MEAN_W-1:0]  p_mean_reg, p_mean_next;
    logic [SH_W-1:0]    p_sh_reg, p_sh_next;
    logic [CNT_W-1:0]   p_index_reg, p_index_next;
    logic               p_last_reg, p_last_next;

    // result stage
    logic               o_valid_reg, o_valid_next;
    logic [CNT_W-1:0]   o_index_reg, o_index_next;
    logic [MEAN_W-1:0]  o_mean_reg, o_mean_next;
    logic [VAR_W-1:0]   o_var_reg, o_var_next;
    logic               o_last_reg, o_last_next;

    logic                   adv_o, adv_p, take;
    logic [MEAN_WIDE_W-1:0] mean_wide;
    logic [PROD_W-1:0]      d;
    logic [VAR_W-1:0]       var_limit;
    logic [VAR_WIDE_W-1:0]  var_wide;

    assign adv_o      = !o_valid_reg || !out_stall;
    assign adv_p      = !p_valid_reg || adv_o;
    assign sums_stall = !adv_p;
    assign take       = sums_valid && adv_p;

    always_comb
    begin
        mean_wide = MEAN_WIDE_W'(sums.sum) << (K_W'(MEAN_FRAC) - sums.k);

        p_valid_next = take ? 1'b1 : (p_valid_reg && !adv_o);
        p_a_next     = p_a_reg;
        p_b_next     = p_b_reg;
        p_mean_next  = p_mean_reg;
        p_sh_next    = p_sh_reg;
        p_index_next = p_index_reg;
        p_last_next  = p_last_reg;
        if (take)
        begin
            // N * sumsq is a shift since N is a power of two
            p_a_next     = PROD_W'(sums.sumsq) << sums.k;
            p_b_next     = PROD_W'(sums.sum) * PROD_W'(sums.sum);
            p_mean_next  = (|mean_wide[MEAN_WIDE_W-1:MEAN_W]) ? '1 : mean_wide[MEAN_W-1:0];
            p_sh_next    = SH_W'(VAR_FRAC) - SH_W'({sums.k, 1'b0});
            p_index_next = sums.index;
            p_last_next  = sums.last;
        end
    end

    always_comb
    begin
        d         = (p_a_reg > p_b_reg) ? p_a_reg - p_b_reg : '0;
        var_limit = VAR_ALL_ONES >> p_sh_reg;
        var_wide  = VAR_WIDE_W'(d) << p_sh_reg;

        o_valid_next = adv_o ? p_valid_reg : o_valid_reg;
        o_index_next = o_index_reg;
        o_mean_next  = o_mean_reg;
        o_var_next   = o_var_reg;
        o_last_next  = o_last_reg;
        if (adv_o && p_valid_reg)
        begin
            o_index_next = p_index_reg;
            o_mean_next  = p_mean_reg;
            o_var_next   = (d > PROD_W'(var_limit)) ? VAR_ALL_ONES : var_wide[VAR_W-1:0];
            o_last_next  = p_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_a_reg     <= p_a_next;
        p_b_reg     <= p_b_next;
        p_mean_reg  <= p_mean_next;
        p_sh_reg    <= p_sh_next;
        p_index_reg <= p_index_next;
        p_last_reg  <= p_last_next;
        o_index_reg <= o_index_next;
        o_mean_reg  <= o_mean_next;
        o_var_reg   <= o_var_next;
        o_last_reg  <= o_last_next;
    end

    assign out_valid      = o_valid_reg;
    assign trial_index    = o_index_reg;
    assign mean_fixed     = o_mean_reg;
    assign variance_fixed = o_var_reg;
    assign final_trial    = o_last_reg;

endmodule

FILE: src/trial_mean_variance.sv
// Per-trial mean and population variance of an unsigned sample stream. One sample is
// accepted every clock cycle while in_stall is low; samples update a running sum and sum
// of squares, and the last sample of a trial hands the totals to a two-stage statistics
// pipeline (square of the sum, then subtract, scale and saturate). The registered totals
// pass through the product and result stages. Input is held off only when the result side
// stalls long enough to fill the totals register and both statistics stages. Only the
// first 2^k samples of a trial are counted, k = floor(log2(samples_per_trial)) capped at
// MAX_LOG2_LENGTH and 20. mean_fixed carries 20 fraction bits, variance_fixed 40. Write
// configuration only while no trial result is pending; cfg_ready is always high.
//
// Top level: configuration registers and the accumulate / statistics chain.
// Depends on tmv_pkg, tmv_accum and tmv_stats.
module trial_mean_variance #(
    parameter int MAX_LOG2_LENGTH = tmv_pkg::DEF_MAX_LOG2_LENGTH,
    parameter int SAMPLE_BITS     = tmv_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tmv_pkg::SAMPLE_W-1:0]   sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tmv_pkg::CNT_W-1:0]      trial_index,
    output logic [tmv_pkg::MEAN_W-1:0]     mean_fixed,
    output logic [tmv_pkg::VAR_W-1:0]      variance_fixed,
    output logic                           final_trial,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmv_pkg::LEN_W-1:0]      cfg_data
);
    import tmv_pkg::*;

    logic [LEN_W-1:0] spt_reg, spt_next;
    logic [CNT_W-1:0] tcount_reg, tcount_next;
    logic             cfg_write;
    logic             sums_valid, sums_stall;
    trial_sums_t      sums;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        spt_next    = spt_reg;
        tcount_next = tcount_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SAMPLES_PER_TRIAL: spt_next    = cfg_data;
                REG_TRIAL_COUNT:       tcount_next = cfg_data[CNT_W-1:0];
                default:               spt_next    = spt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg    <= SAMPLES_PER_TRIAL_RESET;
            tcount_reg <= TRIAL_COUNT_RESET;
        end
        else
        begin
            spt_reg    <= spt_next;
            tcount_reg <= tcount_next;
        end
    end

    tmv_accum #(
        .MAX_LOG2_LENGTH (MAX_LOG2_LENGTH),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .samples_per_trial (spt_reg),
        .trial_count       (tcount_reg),
        .sums_valid        (sums_valid),
        .sums_stall        (sums_stall),
        .sums              (sums)
    );

    tmv_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .sums_valid     (sums_valid),
        .sums_stall     (sums_stall),
        .sums           (sums),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .trial_index    (trial_index),
        .mean_fixed     (mean_fixed),
        .variance_fixed (variance_fixed),
        .final_trial    (final_trial)
    );

endmodule
